/* design/rtcsan_pkg.sv */
// Shared types and constants for the RTC snapshot agreement and normalization block.
// Holds the raw snapshot layout, the normalized result layout and the conversion helpers.
// No dependencies.
package rtcsan_pkg;

    // Register indexes of the configuration port.
    localparam logic REG_BINARY_MODE  = 1'b0;
    localparam logic REG_HOUR_24_MODE = 1'b1;

    localparam logic [7:0]  PM_BIT_MASK  = 8'h80;
    localparam logic [7:0]  HOUR_MASK    = 8'h7F;
    localparam logic [7:0]  NOON_HOUR    = 8'd12;
    localparam logic [7:0]  CENT_LOW     = 8'd19;
    localparam logic [7:0]  CENT_MID     = 8'd20;
    localparam logic [7:0]  CENT_HIGH    = 8'd21;
    localparam logic [11:0] YEAR_1900    = 12'd1900;
    localparam logic [11:0] YEAR_2000    = 12'd2000;
    localparam logic [11:0] YEAR_2100    = 12'd2100;
    localparam logic [11:0] YEAR_MIN     = 12'd1970;
    localparam logic [11:0] YEAR_MAX     = 12'd2199;
    localparam logic [7:0]  SEC_MAX      = 8'd59;
    localparam logic [7:0]  HOUR_MAX     = 8'd23;
    localparam logic [7:0]  DAY_MAX      = 8'd31;
    localparam logic [7:0]  MONTH_MAX    = 8'd12;

    // One raw snapshot; the seconds byte sits in the lowest bits.
    typedef struct packed {
        logic [7:0] cent_raw;
        logic [7:0] yr_raw;
        logic [7:0] mon_raw;
        logic [7:0] day_raw;
        logic [7:0] hour_raw;
        logic [7:0] min_raw;
        logic [7:0] sec_raw;
    } sample_t;

    // One normalized result; the seconds field sits in the lowest bits.
    typedef struct packed {
        logic        time_invalid;
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } result_t;

    typedef struct packed {
        logic binary_mode;
        logic hour_24_mode;
    } cfg_t;

    // Two nibbles weighted as low + 10 * high, also for nibbles above nine.
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return {4'd0, v[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    // Remainder by twelve: reciprocal estimate that is low by at most one, then one fix-up.
    function automatic logic [7:0] mod12(input logic [7:0] v);
        logic [14:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = {7'd0, v} * 15'd85;
        q    = prod[14:10];
        r    = v - 8'({3'd0, q} * 8'd12);
        if (r >= 8'd12) begin
            r = r - 8'd12;
        end
        return r;
    endfunction

endpackage

/* design/rtcsan_agree.sv */
// Snapshot agreement tracker: holds the previous snapshot and the compare count of a read.
// Decides whether the snapshot in the stage register ends the read with a result.
// Depends on rtcsan_pkg.
module rtcsan_agree #(
    parameter int MAX_COMPARES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  rtcsan_pkg::sample_t sample,
    output logic               emit
);

    localparam int CNT_W = $clog2(MAX_COMPARES + 1);

    rtcsan_pkg::sample_t prev_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                held;
    logic                match;

    assign held  = (cnt_reg != '0);
    assign match = (sample == prev_reg);
    assign emit  = held && (match || (cnt_reg >= CNT_W'(MAX_COMPARES)));

    always_comb begin
        cnt_next = cnt_reg;
        if (advance) begin
            if (!held) begin
                cnt_next = CNT_W'(1);
            end else if (emit) begin
                cnt_next = '0;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // The stored snapshot is only compared while the count is nonzero.
    always_ff @(posedge aclk) begin
        if (advance) begin
            prev_reg <= sample;
        end
    end

endmodule

/* design/rtcsan_norm.sv */
// Snapshot normalizer: BCD to binary, 12-hour to 24-hour, full year and range check.
// Purely combinational; sits between the stage register and the result register.
// Depends on rtcsan_pkg.
module rtcsan_norm (
    input  rtcsan_pkg::cfg_t    cfg,
    input  rtcsan_pkg::sample_t sample,
    output rtcsan_pkg::result_t result
);

    logic       pm;
    logic [7:0] hr_strip;
    logic [7:0] sec_c, min_c, hr_c, day_c, mon_c, yr_c, cent_c;
    logic [7:0] hr_24;
    logic [11:0] year_base;
    logic [11:0] year;

    assign pm       = !cfg.hour_24_mode && sample.hour_raw[7];
    assign hr_strip = pm ? (sample.hour_raw & rtcsan_pkg::HOUR_MASK) : sample.hour_raw;

    always_comb begin
        if (cfg.binary_mode) begin
            sec_c  = sample.sec_raw;
            min_c  = sample.min_raw;
            hr_c   = hr_strip;
            day_c  = sample.day_raw;
            mon_c  = sample.mon_raw;
            yr_c   = sample.yr_raw;
            cent_c = sample.cent_raw;
        end else begin
            sec_c  = rtcsan_pkg::from_bcd(sample.sec_raw);
            min_c  = rtcsan_pkg::from_bcd(sample.min_raw);
            hr_c   = rtcsan_pkg::from_bcd(hr_strip);
            day_c  = rtcsan_pkg::from_bcd(sample.day_raw);
            mon_c  = rtcsan_pkg::from_bcd(sample.mon_raw);
            yr_c   = rtcsan_pkg::from_bcd(sample.yr_raw);
            cent_c = rtcsan_pkg::from_bcd(sample.cent_raw);
        end
    end

    // In 12-hour mode, midnight reads as twelve AM, twelve PM stays noon and every other PM hour moves up by twelve.
    always_comb begin
        hr_24 = hr_c;
        if (!cfg.hour_24_mode) begin
            if (pm) begin
                hr_24 = rtcsan_pkg::mod12(hr_c) + rtcsan_pkg::NOON_HOUR;
            end else if (hr_c == rtcsan_pkg::NOON_HOUR) begin
                hr_24 = 8'd0;
            end
        end
    end

    always_comb begin
        case (cent_c)
            rtcsan_pkg::CENT_LOW:  year_base = rtcsan_pkg::YEAR_1900;
            rtcsan_pkg::CENT_MID:  year_base = rtcsan_pkg::YEAR_2000;
            rtcsan_pkg::CENT_HIGH: year_base = rtcsan_pkg::YEAR_2100;
            default:               year_base = rtcsan_pkg::YEAR_2000;
        endcase
    end

    assign year = year_base + {4'd0, yr_c};

    assign result.second       = sec_c;
    assign result.minute       = min_c;
    assign result.hour         = hr_24;
    assign result.day          = day_c;
    assign result.month        = mon_c;
    assign result.year         = year;
    assign result.time_invalid = (sec_c > rtcsan_pkg::SEC_MAX)
                              || (min_c > rtcsan_pkg::SEC_MAX)
                              || (hr_24 > rtcsan_pkg::HOUR_MAX)
                              || (day_c == 8'd0) || (day_c > rtcsan_pkg::DAY_MAX)
                              || (mon_c == 8'd0) || (mon_c > rtcsan_pkg::MONTH_MAX)
                              || (year < rtcsan_pkg::YEAR_MIN)
                              || (year > rtcsan_pkg::YEAR_MAX);

endmodule

/* design/rtc_sample_agree_and_normalize.sv */
// Top level of the RTC snapshot agreement and normalization block.
// Throughput: one item per cycle unless a snapshot that yields a result waits for the
// result register, which is full and stalled; the stage register and the result register
// form a two-deep pipeline, so a new item is taken while a finished result still waits.
// Reset: synchronous, active-low aresetn clears the pipeline valids, the compare
// count and the configuration (binary_mode = 0, hour_24_mode = 1).
module rtc_sample_agree_and_normalize #(
    parameter int MAX_COMPARES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input snapshot channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: sec_raw, min_raw, hour_raw, day_raw, mon_raw, yr_raw, cent_raw.
    input  logic [55:0] s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: second, minute, hour, day, month, year, then 4 zero bits.
    output logic [55:0] m_tdata,
    // m_tuser: time_invalid.
    output logic [0:0]  m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers. A write lands when the access phase completes;
    // the register is chosen by address bit 2, and only bit 0 of the data is kept.
    rtcsan_pkg::cfg_t cfg_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.binary_mode  <= 1'b0;
            cfg_reg.hour_24_mode <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[2])
                rtcsan_pkg::REG_BINARY_MODE:  cfg_reg.binary_mode  <= pwdata[0];
                rtcsan_pkg::REG_HOUR_24_MODE: cfg_reg.hour_24_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rtcsan_pkg::REG_BINARY_MODE:  prdata = {31'd0, cfg_reg.binary_mode};
            rtcsan_pkg::REG_HOUR_24_MODE: prdata = {31'd0, cfg_reg.hour_24_mode};
            default:                      prdata = 32'd0;
        endcase
    end

    // Stage register: holds the accepted snapshot while it is compared and converted.
    logic                stg_valid_reg;
    rtcsan_pkg::sample_t stg_data_reg;
    // Result register: holds a finished result until the sink takes it.
    logic                out_valid_reg;
    rtcsan_pkg::result_t out_data_reg;

    logic                emit;
    logic                out_free;
    logic                stg_advance;
    rtcsan_pkg::result_t norm_result;

    // A snapshot that ends no read always moves on; one that yields a result
    // waits only while the result register is full and not being drained.
    assign out_free    = !out_valid_reg || m_tready;
    assign stg_advance = stg_valid_reg && (!emit || out_free);
    assign s_tready    = !stg_valid_reg || stg_advance;

    rtcsan_agree #(
        .MAX_COMPARES (MAX_COMPARES)
    ) u_agree (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (stg_advance),
        .sample  (stg_data_reg),
        .emit    (emit)
    );

    rtcsan_norm u_norm (
        .cfg    (cfg_reg),
        .sample (stg_data_reg),
        .result (norm_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                stg_valid_reg <= 1'b1;
            end else if (stg_advance) begin
                stg_valid_reg <= 1'b0;
            end

            if (stg_advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stg_data_reg <= rtcsan_pkg::sample_t'(s_tdata);
        end
        if (stg_advance && emit) begin
            out_data_reg <= norm_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg.year, out_data_reg.month, out_data_reg.day,
                       out_data_reg.hour, out_data_reg.minute, out_data_reg.second};
    assign m_tuser  = out_data_reg.time_invalid;

endmodule

/* design/rtcsan_checker.sv */
// Port-level checker for the RTC snapshot agreement and normalization block.
// Bound to rtc_sample_agree_and_normalize; depends on nothing else.
module rtcsan_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // The input side only backs up when the result side is full and stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // A time of day out of range must carry the invalid flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] > 8'd59 || m_tdata[15:8] > 8'd59 || m_tdata[23:16] > 8'd23)
        |-> m_tuser[0])
        else $error("out-of-range time not flagged");

    // A month or day of zero, or a pad bit set, is never reported as valid output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[55:52] == 4'd0)
                  && ((m_tdata[31:24] != 8'd0 && m_tdata[39:32] != 8'd0) || m_tuser[0]))
        else $error("bad result padding or unflagged zero day or month");

endmodule

bind rtc_sample_agree_and_normalize rtcsan_checker u_rtcsan_checker (.*);

/* sim/rtc_sample_agree_and_normalize_test.sv */
// Self-checking testbench for rtc_sample_agree_and_normalize: drives RTC register snapshots,
// predicts the agreed and normalized time for each read, and checks every result item.
// Depends on rtcsan_pkg and the rtc_sample_agree_and_normalize RTL only.
module rtc_sample_agree_and_normalize_test;

    timeunit 1ns;
    timeprecision 1ps;

    // A read ends on the ninth snapshot when no two consecutive ones agree.
    localparam int COMPARE_LIMIT = 8;
    // Cycles that cover the two-stage pipeline plus some slack before a register write.
    localparam int SETTLE_CYCLES = 6;
    // Length of the receiver hold-off that makes the block stall its input.
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [2:0] ADDR_BINARY_MODE  = {rtcsan_pkg::REG_BINARY_MODE, 2'b00};
    localparam logic [2:0] ADDR_HOUR_24_MODE = {rtcsan_pkg::REG_HOUR_24_MODE, 2'b00};

    // One normalized clock reading, as the block should report it.
    typedef struct {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [11:0] year;
        logic        time_invalid;
    } clock_reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata, lowest bit up: sec_raw, min_raw, hour_raw, day_raw, mon_raw, yr_raw, cent_raw.
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata, lowest bit up: second, minute, hour, day, month, year, then 4 zero bits.
    logic [55:0] m_tdata;
    // m_tuser: time_invalid.
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block: its configuration, the snapshot it holds and its compare count.
    logic                mode_binary;
    logic                mode_hour_24;
    rtcsan_pkg::sample_t held_sample;
    logic [3:0]          held_count;
    clock_reading_t      expected_times[$];

    int  fail_count;
    int  items_sent;
    bit  idle_on;
    bit  hold_off_req;

    rtc_sample_agree_and_normalize #(
        .MAX_COMPARES(COMPARE_LIMIT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // A failsafe: a healthy run needs well under a millisecond of simulated time.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Two nibbles weighted as low + 10 * high; nibbles above nine are not rejected.
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
    endfunction

    function automatic clock_reading_t normalize_snapshot(input rtcsan_pkg::sample_t snap);
        logic [7:0]     sec, mn, hr, dy, mo, yr, ce;
        logic           pm;
        clock_reading_t r;
        sec = snap.sec_raw;
        mn  = snap.min_raw;
        hr  = snap.hour_raw;
        dy  = snap.day_raw;
        mo  = snap.mon_raw;
        yr  = snap.yr_raw;
        ce  = snap.cent_raw;
        // In 12-hour mode bit 7 is the PM flag; in 24-hour mode it stays in the hour.
        pm = !mode_hour_24 && hr[7];
        if (pm) begin
            hr[7] = 1'b0;
        end
        if (!mode_binary) begin
            sec = bcd_value(sec);
            mn  = bcd_value(mn);
            hr  = bcd_value(hr);
            dy  = bcd_value(dy);
            mo  = bcd_value(mo);
            yr  = bcd_value(yr);
            ce  = bcd_value(ce);
        end
        // Twelve o'clock is midnight without PM and noon with it.
        if (!mode_hour_24) begin
            if (pm) begin
                hr = (hr % 8'd12) + 8'd12;
            end else if (hr == 8'd12) begin
                hr = 8'd0;
            end
        end
        // Only centuries 19 to 21 are trusted; anything else means the 2000s.
        if (ce >= 8'd19 && ce <= 8'd21) begin
            r.year = 12'(ce) * 12'd100 + 12'(yr);
        end else begin
            r.year = 12'd2000 + 12'(yr);
        end
        r.second = sec;
        r.minute = mn;
        r.hour   = hr;
        r.day    = dy;
        r.month  = mo;
        r.time_invalid = sec > 8'd59 || mn > 8'd59 || hr > 8'd23 || dy < 8'd1 || dy > 8'd31
                         || mo < 8'd1 || mo > 8'd12 || r.year < 12'd1970 || r.year > 12'd2199;
        return r;
    endfunction

    // Advances the shadow state by one accepted snapshot and queues any reading it yields.
    task automatic agree_and_normalize(input rtcsan_pkg::sample_t snap);
        if (held_count == 4'd0) begin
            held_count = 4'd1;
        end else if (snap == held_sample || held_count >= COMPARE_LIMIT) begin
            expected_times.push_back(normalize_snapshot(snap));
            held_count = 4'd0;
        end else begin
            held_count = held_count + 4'd1;
        end
        held_sample = snap;
    endtask

    // ------------------------------------------------------------------
    // Result checking: every accepted result item is matched against the oldest
    // expected reading, field by field.
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        clock_reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_times.size() == 0) begin
                $error("unexpected result item: m_tdata=%h m_tuser=%b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = expected_times.pop_front();
                check_field("second", want.second, m_tdata[7:0]);
                check_field("minute", want.minute, m_tdata[15:8]);
                check_field("hour", want.hour, m_tdata[23:16]);
                check_field("day", want.day, m_tdata[31:24]);
                check_field("month", want.month, m_tdata[39:32]);
                check_field("year", want.year, m_tdata[51:40]);
                check_field("tdata padding", 0, m_tdata[55:52]);
                check_field("time_invalid", want.time_invalid, m_tuser[0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, or one long hold-off on request so that
    // the block's two-deep pipeline fills and it pushes back on its input.
    // ------------------------------------------------------------------

    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration port
    // ------------------------------------------------------------------

    // Offers one snapshot, waits for its handshake and feeds it to the shadow model.
    // s_tvalid is left high so back-to-back items flow without a bubble.
    task automatic send_sample(input rtcsan_pkg::sample_t snap);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= snap;
        do @(posedge aclk); while (!s_tready);
        agree_and_normalize(snap);
        items_sent++;
    endtask

    // Stops offering and waits until every expected reading has come out, plus the
    // pipeline depth, since the last items of a read may produce nothing.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_times.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB write; the upper data bits are random since only bit 0 counts.
    task automatic write_reg(input logic [2:0] addr, input logic value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom & ~32'd1) | 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_BINARY_MODE) begin
            mode_binary = value;
        end else begin
            mode_hour_24 = value;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_modes(input logic binary, input logic hour_24);
        drain_results();
        write_reg(ADDR_BINARY_MODE, binary);
        write_reg(ADDR_HOUR_24_MODE, hour_24);
    endtask

    // ------------------------------------------------------------------
    // Snapshot generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] encode_field(input int v);
        if (mode_binary) begin
            return 8'(v);
        end
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // A snapshot as a healthy RTC would hold it under the current modes, with now and
    // then one byte replaced by noise so that range errors and odd digits show up.
    function automatic rtcsan_pkg::sample_t plausible_snapshot();
        rtcsan_pkg::sample_t snap;
        logic [55:0]         bits;
        int                  h;
        h = $urandom_range(0, 23);
        snap.sec_raw = encode_field($urandom_range(0, 59));
        snap.min_raw = encode_field($urandom_range(0, 59));
        if (mode_hour_24) begin
            snap.hour_raw = encode_field(h);
        end else begin
            snap.hour_raw = encode_field((h % 12 == 0) ? 12 : h % 12);
            snap.hour_raw[7] = (h >= 12);
        end
        snap.day_raw  = encode_field($urandom_range(1, 31));
        snap.mon_raw  = encode_field($urandom_range(1, 12));
        snap.yr_raw   = encode_field($urandom_range(0, 99));
        snap.cent_raw = encode_field($urandom_range(18, 22));
        bits = snap;
        if ($urandom_range(0, 3) == 0) begin
            bits[8 * $urandom_range(0, 6) +: 8] = 8'($urandom);
        end
        return rtcsan_pkg::sample_t'(bits);
    endfunction

    function automatic rtcsan_pkg::sample_t noise_snapshot();
        return rtcsan_pkg::sample_t'(56'({$urandom, $urandom}));
    endfunction

    // Differs from the given snapshot in exactly one bit, so the compare sees every bit.
    function automatic rtcsan_pkg::sample_t flip_one_bit(input rtcsan_pkg::sample_t snap);
        return rtcsan_pkg::sample_t'(56'(snap) ^ (56'd1 << $urandom_range(0, 55)));
    endfunction

    task automatic send_pair(input rtcsan_pkg::sample_t snap);
        send_sample(snap);
        send_sample(snap);
    endtask

    // One read of random shape. Most reads settle after a few ticks, some never
    // settle and run into the compare limit, and the rest is unstructured noise.
    task automatic random_read();
        rtcsan_pkg::sample_t snap;
        int                  pick;
        pick = $urandom_range(0, 9);
        snap = plausible_snapshot();
        if (pick < 7) begin
            send_sample(snap);
            repeat ($urandom_range(0, 2)) begin
                snap = $urandom_range(0, 1) ? flip_one_bit(snap) : plausible_snapshot();
                send_sample(snap);
            end
            send_sample(snap);
        end else if (pick < 8) begin
            send_sample(snap);
            repeat (COMPARE_LIMIT) begin
                snap = flip_one_bit(snap);
                send_sample(snap);
            end
        end else begin
            repeat ($urandom_range(1, 3)) send_sample(noise_snapshot());
        end
    endtask

    task automatic random_reads(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) random_read();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults are BCD and 24-hour; cover the byte extremes, a full valid date,
    // non-BCD digits and the lower year boundary.
    task automatic test_bcd_24_hour();
        send_pair(rtcsan_pkg::sample_t'(56'h00_00_00_00_00_00_00));
        send_pair(rtcsan_pkg::sample_t'(56'hFF_FF_FF_FF_FF_FF_FF));
        send_pair('{cent_raw: 8'h20, yr_raw: 8'h24, mon_raw: 8'h12, day_raw: 8'h31,
                    hour_raw: 8'h23, min_raw: 8'h59, sec_raw: 8'h59});
        // Bit 7 of the hour is part of the value here, and 1969 is just out of range.
        send_pair('{cent_raw: 8'h19, yr_raw: 8'h69, mon_raw: 8'h01, day_raw: 8'h01,
                    hour_raw: 8'h80, min_raw: 8'h00, sec_raw: 8'h00});
    endtask

    // Nine snapshots that never agree end the read without a match.
    task automatic test_compare_limit();
        rtcsan_pkg::sample_t snap;
        snap = plausible_snapshot();
        send_sample(snap);
        repeat (COMPARE_LIMIT) begin
            snap = flip_one_bit(snap);
            send_sample(snap);
        end
    endtask

    // Midnight, noon and an afternoon hour in 12-hour mode, then binary 12-hour mode
    // with the last valid year.
    task automatic test_twelve_hour();
        set_modes(1'b0, 1'b0);
        send_pair('{cent_raw: 8'h20, yr_raw: 8'h00, mon_raw: 8'h06, day_raw: 8'h15,
                    hour_raw: 8'h12, min_raw: 8'h30, sec_raw: 8'h00});
        send_pair('{cent_raw: 8'h20, yr_raw: 8'h00, mon_raw: 8'h06, day_raw: 8'h15,
                    hour_raw: 8'h92, min_raw: 8'h30, sec_raw: 8'h00});
        send_pair('{cent_raw: 8'h20, yr_raw: 8'h00, mon_raw: 8'h06, day_raw: 8'h15,
                    hour_raw: 8'h81, min_raw: 8'h30, sec_raw: 8'h00});
        set_modes(1'b1, 1'b0);
        send_pair('{cent_raw: 8'd21, yr_raw: 8'd99, mon_raw: 8'd12, day_raw: 8'd31,
                    hour_raw: 8'h8B, min_raw: 8'd59, sec_raw: 8'd59});
    endtask

    // Random reads under every combination of the two modes.
    task automatic test_random_modes();
        set_modes(1'b0, 1'b1);
        random_reads(240);
        set_modes(1'b1, 1'b1);
        random_reads(240);
        set_modes(1'b0, 1'b0);
        random_reads(240);
        set_modes(1'b1, 1'b0);
        random_reads(240);
    endtask

    // The receiver holds off for a long time while agreeing pairs keep coming, so
    // results pile up and the input must stall without losing an item.
    task automatic test_input_stall();
        drain_results();
        hold_off_req = 1'b1;
        repeat (20) send_pair(plausible_snapshot());
    endtask

    // Back to the reset modes with no idling on either side.
    task automatic test_full_rate();
        set_modes(1'b0, 1'b1);
        idle_on = 1'b0;
        random_reads(150);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        mode_binary  = 1'b0;
        mode_hour_24 = 1'b1;
        held_sample  = '0;
        held_count   = 4'd0;
        fail_count   = 0;
        items_sent   = 0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_bcd_24_hour();
        test_compare_limit();
        test_twelve_hour();
        test_random_modes();
        test_input_stall();
        test_full_rate();
        drain_results();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
